FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the cache block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Condition never holds on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

FILE: hw/rtl/lrukv_pkg.sv
// Shared types and constants of the key-value cache with expiry.
`default_nettype none
package lrukv_pkg;

   // Table geometry and internal field widths.
   localparam int ENTRIES    = 4;
   localparam int KEY_BITS   = 64;
   localparam int VALUE_BITS = 64;
   localparam int TIME_BITS  = 48;

   // Widths of the request and response ports.
   localparam int PORT_TYPE_BITS  = 2;
   localparam int PORT_KEY_BITS   = 64;
   localparam int PORT_VALUE_BITS = 64;
   localparam int PORT_TTL_BITS   = 32;
   localparam int PORT_NOW_BITS   = 48;

   // Derived widths: slot index and recency rank, usable time and deadline.
   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int NOW_BITS  = (TIME_BITS < PORT_NOW_BITS) ? TIME_BITS : PORT_NOW_BITS;
   localparam int DL_BITS   = ((NOW_BITS > PORT_TTL_BITS) ? NOW_BITS : PORT_TTL_BITS) + 2;
   localparam logic [IDX_BITS-1:0] LAST_RANK = IDX_BITS'(ENTRIES - 1);

   // Request operation codes.
   typedef enum logic [PORT_TYPE_BITS-1:0] {
      OP_SET    = 2'd0,
      OP_GET    = 2'd1,
      OP_DELETE = 2'd2,
      OP_EXPIRE = 2'd3
   } lrukv_op_type;

   // Registered request as seen by the table logic.
   typedef struct packed {
      lrukv_op_type                    op;
      logic [KEY_BITS-1:0]             key;
      logic [VALUE_BITS-1:0]           value;
      logic signed [PORT_TTL_BITS-1:0] ttl;
      logic [NOW_BITS-1:0]             now;
   } lrukv_req_type;

   // Response of one request.
   typedef struct packed {
      logic                  found;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
      logic                  expired;
   } lrukv_rsp_type;

   // Associative search result over the table.
   typedef struct packed {
      logic                hit;
      logic [IDX_BITS-1:0] hit_idx;
      logic                free_found;
      logic [IDX_BITS-1:0] free_idx;
      logic [IDX_BITS-1:0] victim_idx;
   } lrukv_match_type;

endpackage
`default_nettype wire

FILE: hw/rtl/lru_key_value_cache_with_ttl_top.sv
// Top level of the key-value cache with recency replacement and expiry.
// The response strobe is registered: an accepted request passes the request register, then the response register.
// Throughput: one request per cycle outside reset; the store searches and updates the entry flip-flops in one step.
// The response is shown for one cycle under rsp_strobe and cannot be held off.
// Reset clears all entry valid bits at once; busy is high only while reset is applied.
`default_nettype none
module lru_key_value_cache_with_ttl_top
   import lrukv_pkg::*;
(
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [PORT_TYPE_BITS-1:0]         req_type,
   input  wire logic [PORT_KEY_BITS-1:0]          req_key,
   input  wire logic [PORT_VALUE_BITS-1:0]        req_value,
   input  wire logic signed [PORT_TTL_BITS-1:0]   req_ttl_seconds,
   input  wire logic [PORT_NOW_BITS-1:0]          req_now_seconds,
   output logic                                   rsp_strobe,
   output logic                                   rsp_found,
   output logic [PORT_VALUE_BITS-1:0]             rsp_read_value,
   output logic                                   rsp_evicted,
   output logic                                   rsp_expired
);

   logic          req_valid_ff, req_valid_in;
   lrukv_req_type req_ff, req_in;
   logic          rsp_strobe_ff;
   lrukv_rsp_type rsp_ff, rsp_in;

   // Requests are refused only during reset.
   assign busy = reset;

   // Request register.
   assign req_valid_in = start && !busy;
   always_comb begin
      req_in.op    = lrukv_op_type'(req_type);
      req_in.key   = req_key[KEY_BITS-1:0];
      req_in.value = req_value[VALUE_BITS-1:0];
      req_in.ttl   = req_ttl_seconds;
      req_in.now   = req_now_seconds[NOW_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         req_valid_ff  <= req_valid_in;
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // Table search and update.
   lrukv_store u_store (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid_ff),
      .req       (req_ff),
      .rsp       (rsp_in)
   );

   // Response ports.
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_found      = rsp_ff.found;
   assign rsp_read_value = PORT_VALUE_BITS'(rsp_ff.read_value);
   assign rsp_evicted    = rsp_ff.evicted;
   assign rsp_expired    = rsp_ff.expired;

endmodule
`default_nettype wire

FILE: hw/rtl/lrukv_match.sv
// Associative key search, free slot pick and eviction victim pick.
`default_nettype none
module lrukv_match
   import lrukv_pkg::*;
(
   input  wire logic [KEY_BITS-1:0]               key,
   input  wire logic [ENTRIES-1:0]                valid,
   input  wire logic [ENTRIES-1:0][KEY_BITS-1:0]  keys,
   input  wire logic [ENTRIES-1:0][IDX_BITS-1:0]  ranks,
   output lrukv_match_type                        match
);

   // Compare every entry in parallel; the lowest index wins for hit and free slot.
   always_comb begin
      match = '0;
      for (int j = ENTRIES - 1; j >= 0; j--) begin
         if (valid[j] && (keys[j] == key)) begin
            match.hit     = 1'b1;
            match.hit_idx = IDX_BITS'(j);
         end
         if (!valid[j]) begin
            match.free_found = 1'b1;
            match.free_idx   = IDX_BITS'(j);
         end
      end
      // The victim is the valid entry holding the oldest rank.
      for (int j = 0; j < ENTRIES; j++) begin
         if (valid[j] && (ranks[j] == LAST_RANK)) begin
            match.victim_idx = IDX_BITS'(j);
         end
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/lrukv_store.sv
// Entry storage with the per-request update of recency, values and deadlines.
`default_nettype none
module lrukv_store
   import lrukv_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire lrukv_req_type req,
   output lrukv_rsp_type      rsp
);

   logic [ENTRIES-1:0]                  valid_ff, valid_in;
   logic [ENTRIES-1:0][KEY_BITS-1:0]    key_ff, key_in;
   logic [ENTRIES-1:0][VALUE_BITS-1:0]  value_ff, value_in;
   logic [ENTRIES-1:0][DL_BITS-1:0]     dl_ff, dl_in;
   logic [ENTRIES-1:0][IDX_BITS-1:0]    rank_ff, rank_in;

   lrukv_match_type           match;
   logic [IDX_BITS-1:0]       hit_rank;
   logic [DL_BITS-1:0]        hit_dl;
   logic [IDX_BITS-1:0]       slot;
   logic signed [DL_BITS-1:0] now_ext;
   logic signed [DL_BITS-1:0] ttl_ext;
   logic signed [DL_BITS-1:0] dl_sum;
   logic                      dead;

   // Search the table for the request key.
   lrukv_match u_match (
      .key   (req.key),
      .valid (valid_ff),
      .keys  (key_ff),
      .ranks (rank_ff),
      .match (match)
   );

   // Values taken from the hit entry, and the deadline arithmetic.
   assign hit_rank = rank_ff[match.hit_idx];
   assign hit_dl   = dl_ff[match.hit_idx];
   assign now_ext  = DL_BITS'(req.now);
   assign ttl_ext  = DL_BITS'(req.ttl);
   assign dl_sum   = now_ext + ttl_ext;
   assign dead     = (hit_dl != '0) && (now_ext >= $signed(hit_dl));
   assign slot     = match.free_found ? match.free_idx : match.victim_idx;

   // Next table contents and the response of the request.
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      dl_in    = dl_ff;
      rank_in  = rank_ff;
      rsp      = '0;
      if (req_valid) begin
         unique case (req.op)
            OP_SET: begin
               if (match.hit) begin
                  // Overwrite in place and make the entry most recent.
                  rsp.found                = 1'b1;
                  value_in[match.hit_idx]  = req.value;
                  dl_in[match.hit_idx]     = '0;
                  for (int j = 0; j < ENTRIES; j++) begin
                     if ((IDX_BITS'(j) != match.hit_idx) && valid_ff[j] &&
                         (rank_ff[j] < hit_rank)) begin
                        rank_in[j] = rank_ff[j] + 1'b1;
                     end
                  end
                  rank_in[match.hit_idx] = '0;
               end else begin
                  // Fill a free slot or replace the oldest entry; all others age.
                  rsp.evicted = !match.free_found;
                  for (int j = 0; j < ENTRIES; j++) begin
                     if ((IDX_BITS'(j) != slot) && valid_ff[j]) begin
                        rank_in[j] = rank_ff[j] + 1'b1;
                     end
                  end
                  valid_in[slot] = 1'b1;
                  key_in[slot]   = req.key;
                  value_in[slot] = req.value;
                  dl_in[slot]    = '0;
                  rank_in[slot]  = '0;
               end
            end
            OP_GET: begin
               if (match.hit) begin
                  if (dead) begin
                     // Deadline reached: drop the entry and close the rank gap.
                     rsp.expired             = 1'b1;
                     valid_in[match.hit_idx] = 1'b0;
                     for (int j = 0; j < ENTRIES; j++) begin
                        if (valid_ff[j] && (rank_ff[j] > hit_rank)) begin
                           rank_in[j] = rank_ff[j] - 1'b1;
                        end
                     end
                  end else begin
                     rsp.found      = 1'b1;
                     rsp.read_value = value_ff[match.hit_idx];
                     for (int j = 0; j < ENTRIES; j++) begin
                        if ((IDX_BITS'(j) != match.hit_idx) && valid_ff[j] &&
                            (rank_ff[j] < hit_rank)) begin
                           rank_in[j] = rank_ff[j] + 1'b1;
                        end
                     end
                     rank_in[match.hit_idx] = '0;
                  end
               end
            end
            OP_DELETE: begin
               if (match.hit) begin
                  rsp.found               = 1'b1;
                  valid_in[match.hit_idx] = 1'b0;
                  for (int j = 0; j < ENTRIES; j++) begin
                     if (valid_ff[j] && (rank_ff[j] > hit_rank)) begin
                        rank_in[j] = rank_ff[j] - 1'b1;
                     end
                  end
               end
            end
            OP_EXPIRE: begin
               // Store the new deadline; recency is left alone.
               if (match.hit) begin
                  rsp.found            = 1'b1;
                  dl_in[match.hit_idx] = dl_sum;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Valid bits are control state and clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Entry payload is only read while valid.
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      dl_ff    <= dl_in;
      rank_ff  <= rank_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/lrukv_checker.sv
// Port-level checker of the cache top level and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module lrukv_checker
   import lrukv_pkg::*;
(
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic [PORT_TYPE_BITS-1:0]         req_type,
   input wire logic [PORT_KEY_BITS-1:0]          req_key,
   input wire logic [PORT_VALUE_BITS-1:0]        req_value,
   input wire logic signed [PORT_TTL_BITS-1:0]   req_ttl_seconds,
   input wire logic [PORT_NOW_BITS-1:0]          req_now_seconds,
   input wire logic                              rsp_strobe,
   input wire logic                              rsp_found,
   input wire logic [PORT_VALUE_BITS-1:0]        rsp_read_value,
   input wire logic                              rsp_evicted,
   input wire logic                              rsp_expired
);

   // Every accepted request gives exactly one response, through the request and response registers.
   `ASSERT_IMPLY(a_rsp_follows_req, clock, reset, start && !busy, ##2 rsp_strobe)
   `ASSERT_IMPLY(a_no_spurious_rsp, clock, reset, rsp_strobe, $past(start && !busy, 2))

   // An eviction or expiry never reports a live hit, and only a hit returns data.
   `ASSERT_IMPLY(a_evict_or_expire_no_hit, clock, reset,
      rsp_strobe && (rsp_evicted || rsp_expired), !rsp_found && !(rsp_evicted && rsp_expired))
   `ASSERT_IMPLY(a_data_needs_hit, clock, reset,
      rsp_strobe && (rsp_read_value != '0), rsp_found && !rsp_evicted)

endmodule

bind lru_key_value_cache_with_ttl_top lrukv_checker u_checker (.*);
`default_nettype wire

FILE: bench/lrukv_checker.sv
// Response checker for the key-value cache: predicts each response and compares it.
`timescale 1ns / 100ps
module lrukv_rsp_checker
   import lrukv_pkg::*;
(
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic [PORT_TYPE_BITS-1:0]       req_type,
   input  wire logic [PORT_KEY_BITS-1:0]        req_key,
   input  wire logic [PORT_VALUE_BITS-1:0]      req_value,
   input  wire logic signed [PORT_TTL_BITS-1:0] req_ttl_seconds,
   input  wire logic [PORT_NOW_BITS-1:0]        req_now_seconds,
   input  wire logic                            rsp_strobe,
   input  wire logic                            rsp_found,
   input  wire logic [PORT_VALUE_BITS-1:0]      rsp_read_value,
   input  wire logic                            rsp_evicted,
   input  wire logic                            rsp_expired,
   output int                                   fail_count,
   output int                                   outstanding
);

   // Shadow copy of the cache table.
   logic                       slot_live     [ENTRIES];
   logic [KEY_BITS-1:0]        slot_key      [ENTRIES];
   logic [VALUE_BITS-1:0]      slot_value    [ENTRIES];
   logic signed [DL_BITS-1:0]  slot_deadline [ENTRIES];
   logic [IDX_BITS-1:0]        slot_rank     [ENTRIES];

   // Responses predicted for accepted requests, oldest first.
   lrukv_rsp_type pending_rsp_q[$];

   // Returns the slot that holds the key, or -1 when it is absent.
   function automatic int find_slot(logic [KEY_BITS-1:0] key);
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_live[i] && slot_key[i] == key) return i;
      end
      return -1;
   endfunction

   // Makes a slot most recent; entries that were more recent age by one.
   function automatic void promote_slot(int idx);
      logic [IDX_BITS-1:0] old_rank;
      old_rank = slot_rank[idx];
      for (int j = 0; j < ENTRIES; j++) begin
         if (j != idx && slot_live[j] && slot_rank[j] < old_rank) slot_rank[j]++;
      end
      slot_rank[idx] = '0;
   endfunction

   // Frees a slot and closes the gap it leaves in the recency order.
   function automatic void drop_slot(int idx);
      logic [IDX_BITS-1:0] old_rank;
      old_rank = slot_rank[idx];
      slot_live[idx] = 1'b0;
      for (int j = 0; j < ENTRIES; j++) begin
         if (slot_live[j] && slot_rank[j] > old_rank) slot_rank[j]--;
      end
   endfunction

   // Applies one request to the shadow table and returns its response.
   function automatic lrukv_rsp_type apply_request(lrukv_op_type op,
                                                   logic [KEY_BITS-1:0] key,
                                                   logic [VALUE_BITS-1:0] value,
                                                   logic signed [PORT_TTL_BITS-1:0] ttl,
                                                   logic [NOW_BITS-1:0] now);
      lrukv_rsp_type rsp;
      logic signed [DL_BITS-1:0] now_s;
      logic signed [DL_BITS-1:0] ttl_s;
      int hit;
      int slot;
      int best;
      rsp = '0;
      now_s = {{(DL_BITS-NOW_BITS){1'b0}}, now};
      ttl_s = DL_BITS'(ttl);
      hit = find_slot(key);
      case (op)
         OP_SET: begin
            if (hit >= 0) begin
               rsp.found = 1'b1;
               slot_value[hit] = value;
               slot_deadline[hit] = '0;
               promote_slot(hit);
            end else begin
               // Take the lowest free slot, or evict the least recent entry.
               slot = -1;
               for (int j = 0; j < ENTRIES; j++) begin
                  if (!slot_live[j] && slot < 0) slot = j;
               end
               if (slot < 0) begin
                  best = 0;
                  slot = 0;
                  for (int j = 0; j < ENTRIES; j++) begin
                     if (int'(slot_rank[j]) >= best) begin
                        best = int'(slot_rank[j]);
                        slot = j;
                     end
                  end
                  drop_slot(slot);
                  rsp.evicted = 1'b1;
               end
               for (int j = 0; j < ENTRIES; j++) begin
                  if (slot_live[j]) slot_rank[j]++;
               end
               slot_live[slot] = 1'b1;
               slot_key[slot] = key;
               slot_value[slot] = value;
               slot_deadline[slot] = '0;
               slot_rank[slot] = '0;
            end
         end
         OP_GET: begin
            if (hit >= 0) begin
               // A nonzero deadline that the current time has reached kills the entry.
               if (slot_deadline[hit] != 0 && now_s >= slot_deadline[hit]) begin
                  drop_slot(hit);
                  rsp.expired = 1'b1;
               end else begin
                  rsp.found = 1'b1;
                  rsp.read_value = slot_value[hit];
                  promote_slot(hit);
               end
            end
         end
         OP_DELETE: begin
            if (hit >= 0) begin
               rsp.found = 1'b1;
               drop_slot(hit);
            end
         end
         default: begin
            if (hit >= 0) begin
               rsp.found = 1'b1;
               slot_deadline[hit] = now_s + ttl_s;
            end
         end
      endcase
      return rsp;
   endfunction

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   // Compare the response of this edge first, then predict the request taken at it.
   always @(posedge clock) begin
      lrukv_rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_live[i] = 1'b0;
            slot_key[i] = '0;
            slot_value[i] = '0;
            slot_deadline[i] = '0;
            slot_rank[i] = '0;
         end
         pending_rsp_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_rsp_q.size() == 0) begin
               $error("response strobe with no request waiting");
               fail_count++;
            end else begin
               want = pending_rsp_q.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_found);
                  fail_count++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %h, actual %h", want.read_value,
                         rsp_read_value);
                  fail_count++;
               end
               if (rsp_evicted !== want.evicted) begin
                  $error("evicted: expected %0d, actual %0d", want.evicted, rsp_evicted);
                  fail_count++;
               end
               if (rsp_expired !== want.expired) begin
                  $error("expired: expected %0d, actual %0d", want.expired, rsp_expired);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            pending_rsp_q.push_back(apply_request(lrukv_op_type'(req_type),
                                                  req_key[KEY_BITS-1:0],
                                                  req_value[VALUE_BITS-1:0],
                                                  req_ttl_seconds,
                                                  req_now_seconds[NOW_BITS-1:0]));
         end
      end
      outstanding = pending_rsp_q.size();
   end

endmodule

FILE: bench/tb_lru_key_value_cache_with_ttl_top.sv
// Testbench top of the key-value cache: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_lru_key_value_cache_with_ttl_top;
   import lrukv_pkg::*;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [PORT_TYPE_BITS-1:0]       req_type;
   logic [PORT_KEY_BITS-1:0]        req_key;
   logic [PORT_VALUE_BITS-1:0]      req_value;
   logic signed [PORT_TTL_BITS-1:0] req_ttl_seconds;
   logic [PORT_NOW_BITS-1:0]        req_now_seconds;
   logic                            rsp_strobe;
   logic                            rsp_found;
   logic [PORT_VALUE_BITS-1:0]      rsp_read_value;
   logic                            rsp_evicted;
   logic                            rsp_expired;
   int                              fail_count;
   int                              outstanding;

   // Gaps between requests are allowed only while this is set.
   logic                            gaps_on;

   // Keys and values used by the directed requests.
   localparam logic [63:0] KEY_ZERO = 64'h0;
   localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] KEY_ODD  = 64'h5555_5555_5555_5555;
   localparam logic [63:0] KEY_EVEN = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [63:0] KEY_MIX  = 64'h0123_4567_89AB_CDEF;
   localparam logic [47:0] NOW_MAX  = 48'hFFFF_FFFF_FFFF;

   lru_key_value_cache_with_ttl_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_value       (req_value),
      .req_ttl_seconds (req_ttl_seconds),
      .req_now_seconds (req_now_seconds),
      .rsp_strobe      (rsp_strobe),
      .rsp_found       (rsp_found),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_expired     (rsp_expired)
   );

   lrukv_rsp_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_value       (req_value),
      .req_ttl_seconds (req_ttl_seconds),
      .req_now_seconds (req_now_seconds),
      .rsp_strobe      (rsp_strobe),
      .rsp_found       (rsp_found),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_expired     (rsp_expired),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Ends a run that hangs.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Drives one request at the falling edge and holds it until the block takes it.
   task automatic send_request(input lrukv_op_type op, input logic [63:0] key,
                               input logic [63:0] value, input logic signed [31:0] ttl,
                               input logic [47:0] now);
      if (gaps_on && $urandom_range(0, 99) < 22) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 1)) @(negedge clock);
      end
      @(negedge clock);
      req_type = op;
      req_key = key;
      req_value = value;
      req_ttl_seconds = ttl;
      req_now_seconds = now;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Holds off new requests until every predicted response has come back.
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      logic [63:0]        key_pool [6];
      logic [63:0]        key;
      logic [47:0]        clock_now;
      logic [47:0]        now;
      logic signed [31:0] ttl;
      lrukv_op_type       op;
      int                 pick;
      int                 drain;

      reset = 1'b1;
      start = 1'b0;
      req_type = OP_SET;
      req_key = '0;
      req_value = '0;
      req_ttl_seconds = '0;
      req_now_seconds = '0;
      gaps_on = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Misses on an empty table.
      send_request(OP_GET, KEY_ZERO, '0, '0, '0);
      send_request(OP_DELETE, KEY_ZERO, '0, '0, '0);
      send_request(OP_EXPIRE, KEY_ZERO, '0, 32'sd5, '0);
      // Fill the table, refresh one entry, then force an eviction of the least recent.
      send_request(OP_SET, KEY_ZERO, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
      send_request(OP_SET, KEY_ONES, 64'h0, '0, '0);
      send_request(OP_SET, KEY_ODD, KEY_ODD, '0, '0);
      send_request(OP_SET, KEY_EVEN, KEY_EVEN, '0, '0);
      send_request(OP_GET, KEY_ZERO, '0, '0, '0);
      send_request(OP_SET, KEY_MIX, KEY_MIX, '0, '0);
      send_request(OP_SET, KEY_ODD, 64'h1, '0, '0);
      // Largest deadline stays live at the latest time.
      send_request(OP_EXPIRE, KEY_ODD, '0, 32'sh7FFF_FFFF, NOW_MAX);
      send_request(OP_GET, KEY_ODD, '0, '0, NOW_MAX);
      // Negative deadline is already reached.
      send_request(OP_EXPIRE, KEY_EVEN, '0, 32'sh8000_0000, '0);
      send_request(OP_GET, KEY_EVEN, '0, '0, '0);
      // A deadline that sums to zero means the entry never expires.
      send_request(OP_EXPIRE, KEY_ZERO, '0, -32'sd5, 48'd5);
      send_request(OP_GET, KEY_ZERO, '0, '0, NOW_MAX);
      // Expiry just before and exactly at the deadline.
      send_request(OP_EXPIRE, KEY_MIX, '0, 32'sd10, 48'd100);
      send_request(OP_GET, KEY_MIX, '0, '0, 48'd109);
      send_request(OP_GET, KEY_MIX, '0, '0, 48'd110);
      // A dead entry still counts as present for set and delete.
      send_request(OP_EXPIRE, KEY_ODD, '0, 32'sd1, '0);
      send_request(OP_SET, KEY_ODD, 64'h2, '0, 48'd500);
      send_request(OP_GET, KEY_ODD, '0, '0, 48'd1000);
      send_request(OP_EXPIRE, KEY_ZERO, '0, 32'sd1, '0);
      send_request(OP_DELETE, KEY_ZERO, '0, '0, 48'd10);
      // New key goes to the lowest free slot.
      send_request(OP_SET, KEY_ONES, KEY_ONES, '0, 48'd10);

      // Random requests over a small key pool so that hits, evictions and expiry occur.
      for (int i = 0; i < 6; i++) key_pool[i] = {$urandom, $urandom};
      clock_now = 48'd1000;
      for (int n = 0; n < 1300; n++) begin
         gaps_on = !(n >= 400 && n < 600);
         if (n == 900) wait_drained();
         if ($urandom_range(0, 99) < 2) key_pool[$urandom_range(0, 5)] = {$urandom, $urandom};
         pick = $urandom_range(0, 99);
         if (pick < 35) op = OP_SET;
         else if (pick < 70) op = OP_GET;
         else if (pick < 80) op = OP_DELETE;
         else op = OP_EXPIRE;
         key = ($urandom_range(0, 99) < 10) ? {$urandom, $urandom}
                                            : key_pool[$urandom_range(0, 5)];
         clock_now = clock_now + 48'($urandom_range(0, 8));
         now = ($urandom_range(0, 99) < 4) ? {16'($urandom), $urandom} : clock_now;
         pick = $urandom_range(0, 99);
         if (pick < 6) ttl = $urandom;
         else if (pick < 10) ttl = -$signed(32'(now));
         else ttl = 32'($urandom_range(0, 60)) - 32'sd10;
         send_request(op, key, {$urandom, $urandom}, ttl, now);
      end

      // Let the last responses arrive, then allow for the pipeline latency.
      @(negedge clock);
      start = 1'b0;
      for (drain = 0; drain < 200 && outstanding != 0; drain++) @(negedge clock);
      repeat (4) @(negedge clock);
      if (outstanding != 0) $error("%0d predicted responses never arrived", outstanding);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
